[rtl/mcps_pkg.sv]
package mcps_pkg;

  // Default controller count on the bus
  localparam int NUM_CONTROLLERS_DEF = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration reset values
  localparam logic [7:0]  BASE_ADDRESS_RST = 8'h80;
  localparam logic [15:0] BOOT_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd50;
  localparam logic [15:0] POLL_TIMEOUT_RST = 16'd20;
  localparam logic [9:0]  MIN_VOLTAGE_RST  = 10'd60;
  localparam logic [9:0]  MAX_VOLTAGE_RST  = 10'd180;

  localparam logic [15:0] MS_SATURATE      = 16'hFFFF;
  localparam logic [15:0] STATUS_TIMEOUT_W = 16'hFFFF;
  localparam logic [7:0]  POS_MIN_LEN      = 8'd8;
  localparam logic [7:0]  STATUS_MIN_LEN   = 8'd2;

  typedef enum logic [2:0] {
    CFG_BASE_ADDRESS = 3'd0,
    CFG_BOOT_TIMEOUT = 3'd1,
    CFG_ACK_TIMEOUT  = 3'd2,
    CFG_POLL_TIMEOUT = 3'd3,
    CFG_MIN_VOLTAGE  = 3'd4,
    CFG_MAX_VOLTAGE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_STEP         = 3'd0,
    CMD_SET_SETPOINT = 3'd1,
    CMD_SET_ENABLE   = 3'd2,
    CMD_REQ_RESET    = 3'd3,
    CMD_READ_POS     = 3'd4,
    CMD_READ_STATUS  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_VERSION    = 3'd0,
    OP_PID        = 3'd1,
    OP_RESET_ENC  = 3'd2,
    OP_VOLTAGE    = 3'd3,
    OP_DRIVE      = 3'd4,
    OP_GET_POS    = 3'd5,
    OP_GET_STATUS = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_BOOT   = 3'd0,
    ST_INIT   = 3'd1,
    ST_DRIVE  = 3'd2,
    ST_POLL   = 3'd3,
    ST_STATUS = 3'd4,
    ST_RESET  = 3'd5
  } seq_state_t;

  typedef enum logic [3:0] {
    PH_VERSION      = 4'd0,
    PH_VERSION_WAIT = 4'd1,
    PH_PID0         = 4'd2,
    PH_PID0_WAIT    = 4'd3,
    PH_PID1         = 4'd4,
    PH_PID1_WAIT    = 4'd5,
    PH_ENC          = 4'd6,
    PH_ENC_WAIT     = 4'd7,
    PH_VOLT         = 4'd8,
    PH_VOLT_WAIT    = 4'd9,
    PH_NEXT_CTRL    = 4'd10
  } init_phase_t;

  typedef struct packed {
    logic [7:0]  base_address;
    logic [15:0] boot_timeout_ms;
    logic [15:0] ack_timeout_ms;
    logic [15:0] poll_timeout_ms;
    logic [9:0]  min_voltage_tenths;
    logic [9:0]  max_voltage_tenths;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        elapsed_ms;
    logic               has_ack;
    logic               has_response;
    logic [7:0]         response_len;
    logic [31:0]        response_word0;
    logic [31:0]        response_word1;
    logic [2:0]         item_index;
    logic signed [31:0] setpoint_value;
    logic               enable_value;
  } in_item_t;

  typedef struct packed {
    logic               send_valid;
    logic [2:0]         send_op;
    logic [7:0]         send_address;
    logic signed [31:0] send_arg_a;
    logic signed [31:0] send_arg_b;
    logic [31:0]        read_data;
    logic [2:0]         main_state;
  } out_item_t;

endpackage

[rtl/mcps_cfg.sv]
module mcps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mcps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output mcps_pkg::cfg_t                     cfg
);
  import mcps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address       <= BASE_ADDRESS_RST;
      cfg_r.boot_timeout_ms    <= BOOT_TIMEOUT_RST;
      cfg_r.ack_timeout_ms     <= ACK_TIMEOUT_RST;
      cfg_r.poll_timeout_ms    <= POLL_TIMEOUT_RST;
      cfg_r.min_voltage_tenths <= MIN_VOLTAGE_RST;
      cfg_r.max_voltage_tenths <= MAX_VOLTAGE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_ADDRESS: cfg_r.base_address       <= cfg_wdata[7:0];
        CFG_BOOT_TIMEOUT: cfg_r.boot_timeout_ms    <= cfg_wdata;
        CFG_ACK_TIMEOUT:  cfg_r.ack_timeout_ms     <= cfg_wdata;
        CFG_POLL_TIMEOUT: cfg_r.poll_timeout_ms    <= cfg_wdata;
        CFG_MIN_VOLTAGE:  cfg_r.min_voltage_tenths <= cfg_wdata[9:0];
        CFG_MAX_VOLTAGE:  cfg_r.max_voltage_tenths <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/mcps_seq.sv]
module mcps_seq #(
  parameter int NUM_CONTROLLERS = mcps_pkg::NUM_CONTROLLERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  mcps_pkg::in_item_t   item,
  input  mcps_pkg::cfg_t       cfg,
  output mcps_pkg::out_item_t  result
);
  import mcps_pkg::*;

  localparam int CCW = $clog2(NUM_CONTROLLERS + 1);
  localparam int RW  = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam logic [CCW-1:0] NC     = CCW'(NUM_CONTROLLERS);
  localparam logic [CCW-1:0] CC_ONE = CCW'(1);
  localparam logic [7:0]     NC8    = 8'(NUM_CONTROLLERS);
  localparam logic [7:0]     NM8    = 8'(2 * NUM_CONTROLLERS);

  // Sequencer state
  seq_state_t    state_r, state_nxt;
  init_phase_t   phase_r, phase_nxt;
  logic [CCW-1:0] cc_r, cc_nxt;
  logic          fresh_r, fresh_nxt;
  logic          en_r, en_nxt;
  logic          rp_r, rp_nxt;
  logic [15:0]   since_r, since_nxt;

  // Setpoints and positions split into even (lo) and odd (hi) motor of each controller
  logic [31:0] sp_lo_r  [NUM_CONTROLLERS];
  logic [31:0] sp_hi_r  [NUM_CONTROLLERS];
  logic [31:0] pos_lo_r [NUM_CONTROLLERS];
  logic [31:0] pos_hi_r [NUM_CONTROLLERS];
  logic [15:0] stat_r   [NUM_CONTROLLERS];

  cmd_t          cmd;
  logic [7:0]    idx_ext;
  logic          motor_ok, ctrl_ok;
  logic [RW-1:0] motor_row, ctrl_row, cc_row, prev_row;
  logic [16:0]   since_sum17;
  logic [15:0]   since_sum;
  logic          to_boot, to_ack, to_poll;
  logic [CCW-1:0] cc_plus, cc_prev, rcc;
  logic          prev_ok;
  logic          issue, go, enter;
  op_t           issue_op;
  logic [CCW-1:0] issue_cc;
  seq_state_t    enter_st;
  logic          sp_we, pos_we, st_we;
  logic [15:0]   st_data;

  assign cmd       = cmd_t'(item.command);
  assign idx_ext   = {5'd0, item.item_index};
  assign motor_ok  = idx_ext < NM8;
  assign ctrl_ok   = idx_ext < NC8;
  assign motor_row = idx_ext[RW:1];
  assign ctrl_row  = idx_ext[RW-1:0];
  assign cc_row    = cc_r[RW-1:0];
  assign cc_plus   = cc_r + CC_ONE;
  assign cc_prev   = cc_r - CC_ONE;
  assign prev_row  = cc_prev[RW-1:0];
  assign prev_ok   = (cc_r >= CC_ONE) && (cc_r <= NC);

  assign since_sum17 = {1'b0, since_r} + {1'b0, item.elapsed_ms};
  assign since_sum   = since_sum17[16] ? MS_SATURATE : since_sum17[15:0];
  assign to_boot     = since_sum >= cfg.boot_timeout_ms;
  assign to_ack      = since_sum >= cfg.ack_timeout_ms;
  assign to_poll     = since_sum >= cfg.poll_timeout_ms;

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cc_nxt    = cc_r;
    fresh_nxt = fresh_r;
    en_nxt    = en_r;
    rp_nxt    = rp_r;
    since_nxt = since_r;
    issue     = 1'b0;
    issue_op  = OP_VERSION;
    issue_cc  = cc_r;
    go        = 1'b0;
    enter     = 1'b0;
    enter_st  = ST_BOOT;
    rcc       = cc_r;
    sp_we     = 1'b0;
    pos_we    = 1'b0;
    st_we     = 1'b0;
    st_data   = STATUS_TIMEOUT_W;

    unique case (cmd)
      CMD_STEP: begin
        since_nxt = since_sum;
        if ((state_r == ST_DRIVE || state_r == ST_POLL || state_r == ST_STATUS) && !en_r) begin
          enter    = 1'b1;
          enter_st = ST_BOOT;
        end else begin
          unique case (state_r)
            ST_INIT: begin
              unique case (phase_r)
                PH_VERSION: begin
                  issue = 1'b1; issue_op = OP_VERSION; phase_nxt = PH_VERSION_WAIT;
                end
                PH_VERSION_WAIT: begin
                  if (item.has_response) phase_nxt = PH_PID0;
                  else if (to_boot) phase_nxt = PH_VERSION;
                end
                PH_PID0: begin
                  issue = 1'b1; issue_op = OP_PID; phase_nxt = PH_PID0_WAIT;
                end
                PH_PID1: begin
                  issue = 1'b1; issue_op = OP_PID; phase_nxt = PH_PID1_WAIT;
                end
                PH_ENC: begin
                  issue = 1'b1; issue_op = OP_RESET_ENC; phase_nxt = PH_ENC_WAIT;
                end
                PH_VOLT: begin
                  issue = 1'b1; issue_op = OP_VOLTAGE; phase_nxt = PH_VOLT_WAIT;
                end
                PH_PID0_WAIT, PH_PID1_WAIT, PH_ENC_WAIT, PH_VOLT_WAIT: begin
                  if (item.has_ack || to_ack) phase_nxt = init_phase_t'(phase_r + 4'd1);
                end
                default: begin
                  cc_nxt    = cc_plus;
                  phase_nxt = PH_VERSION;
                  if (cc_plus >= NC) begin
                    enter    = 1'b1;
                    enter_st = rp_r ? ST_RESET : ST_DRIVE;
                  end
                end
              endcase
            end
            ST_DRIVE: begin
              fresh_nxt = 1'b0;
              if (fresh_r || item.has_ack || to_poll) begin
                if (cc_r >= NC) begin
                  enter = 1'b1; enter_st = ST_POLL;
                end else begin
                  issue = 1'b1; issue_op = OP_DRIVE; cc_nxt = cc_plus;
                end
              end
            end
            ST_POLL: begin
              fresh_nxt = 1'b0;
              go        = fresh_r;
              if (item.has_response) begin
                go     = 1'b1;
                pos_we = prev_ok && (item.response_len >= POS_MIN_LEN);
              end else if (to_poll) begin
                go = 1'b1;
              end
              if (go) begin
                if (cc_r >= NC) begin
                  enter = 1'b1; enter_st = ST_STATUS;
                end else begin
                  issue = 1'b1; issue_op = OP_GET_POS; cc_nxt = cc_plus;
                end
              end
            end
            ST_STATUS: begin
              fresh_nxt = 1'b0;
              go        = fresh_r;
              if (item.has_response) begin
                go      = 1'b1;
                st_we   = prev_ok && (item.response_len >= STATUS_MIN_LEN);
                st_data = item.response_word0[31:16];
              end else if (to_poll) begin
                go      = 1'b1;
                st_we   = prev_ok;
                st_data = STATUS_TIMEOUT_W;
              end
              if (go) begin
                if (cc_r >= NC) begin
                  enter = 1'b1; enter_st = ST_DRIVE;
                end else begin
                  issue = 1'b1; issue_op = OP_GET_STATUS; cc_nxt = cc_plus;
                end
              end
            end
            ST_RESET: begin
              fresh_nxt = 1'b0;
              go        = fresh_r;
              if (item.has_ack) begin
                go = 1'b1;
              end else if (to_poll) begin
                // restart the pass at the first controller
                rcc = '0;
                go  = 1'b1;
              end
              if (go) begin
                if (rcc >= NC) begin
                  rp_nxt = 1'b0;
                  enter  = 1'b1; enter_st = ST_DRIVE;
                end else begin
                  issue    = 1'b1;
                  issue_op = OP_RESET_ENC;
                  issue_cc = rcc;
                  cc_nxt   = rcc + CC_ONE;
                end
              end
            end
            default: begin
              if (to_boot) begin
                enter = 1'b1; enter_st = ST_INIT;
              end
            end
          endcase
        end
        if (issue) since_nxt = '0;
        if (enter) begin
          state_nxt = enter_st;
          phase_nxt = PH_VERSION;
          cc_nxt    = '0;
          fresh_nxt = 1'b1;
          since_nxt = '0;
        end
      end
      CMD_SET_SETPOINT: sp_we  = motor_ok;
      CMD_SET_ENABLE:   en_nxt = item.enable_value;
      CMD_REQ_RESET:    rp_nxt = 1'b1;
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    result            = '0;
    result.main_state = state_nxt;
    if (issue) begin
      result.send_valid   = 1'b1;
      result.send_op      = issue_op;
      result.send_address = cfg.base_address + 8'(issue_cc);
      unique case (issue_op)
        OP_PID:     result.send_arg_a = (phase_r == PH_PID1) ? 32'sd1 : 32'sd0;
        OP_VOLTAGE: begin
          result.send_arg_a = {22'd0, cfg.min_voltage_tenths};
          result.send_arg_b = {22'd0, cfg.max_voltage_tenths};
        end
        OP_DRIVE: begin
          result.send_arg_a = sp_lo_r[cc_row];
          result.send_arg_b = sp_hi_r[cc_row];
        end
        default: ;
      endcase
    end
    if (cmd == CMD_READ_POS && motor_ok) begin
      result.read_data = item.item_index[0] ? pos_hi_r[motor_row] : pos_lo_r[motor_row];
    end else if (cmd == CMD_READ_STATUS && ctrl_ok) begin
      result.read_data = {16'd0, stat_r[ctrl_row]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
      phase_r <= PH_VERSION;
      cc_r    <= '0;
      fresh_r <= 1'b1;
      en_r    <= 1'b0;
      rp_r    <= 1'b0;
      since_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cc_r    <= cc_nxt;
      fresh_r <= fresh_nxt;
      en_r    <= en_nxt;
      rp_r    <= rp_nxt;
      since_r <= since_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CONTROLLERS; k++) begin
        sp_lo_r[k]  <= '0;
        sp_hi_r[k]  <= '0;
        pos_lo_r[k] <= '0;
        pos_hi_r[k] <= '0;
        stat_r[k]   <= '0;
      end
    end else if (fire) begin
      if (sp_we) begin
        if (item.item_index[0]) sp_hi_r[motor_row] <= item.setpoint_value;
        else                    sp_lo_r[motor_row] <= item.setpoint_value;
      end
      if (pos_we) begin
        pos_lo_r[prev_row] <= item.response_word0;
        pos_hi_r[prev_row] <= item.response_word1;
      end
      if (st_we) stat_r[prev_row] <= st_data;
    end
  end

endmodule

[rtl/motor_controller_poll_sequencer_unit.sv]
// Path: a word accepted into the input register is processed by the sequencer, and its result
//   word is held in the result register and presented on out_*.
// Throughput: one word per cycle; the input register refills whenever the result register
//   is free or being taken, so a stalled output holds at most two words in flight.
// Reset: synchronous, active low; clears the sequencer to boot, all stored tables to zero
//   and the configuration registers to their defaults.
module motor_controller_poll_sequencer_unit #(
  parameter int NUM_CONTROLLERS = mcps_pkg::NUM_CONTROLLERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mcps_pkg::in_item_t                in_data,
  // result word channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output mcps_pkg::out_item_t               out_data,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [mcps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mcps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mcps_pkg::*;

  // Input register: holds one word until the sequencer consumes it
  logic      in_valid_r;
  in_item_t  in_item_r;
  // Result register: holds one finished word until the consumer takes it
  logic      out_valid_r;
  out_item_t out_item_r;

  cfg_t      cfg;
  out_item_t result;
  logic      proc_fire;

  // Advance the held word whenever the result register can take its result
  assign proc_fire = in_valid_r && (!out_valid_r || out_ready);
  // Accept a new word whenever the input register is empty or draining this cycle
  assign in_ready  = !in_valid_r || proc_fire;

  mcps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // All state updates and the result word come from one pass over the held word
  mcps_seq #(
    .NUM_CONTROLLERS (NUM_CONTROLLERS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (proc_fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; load only on a fresh accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      // drop the word once taken
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
